### hw/rtl/catmull_rom_curve_point_assert.svh
// Assertion macros used by the curve point checker.
`ifndef CATMULL_ROM_CURVE_POINT_ASSERT_SVH
`define CATMULL_ROM_CURVE_POINT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define CRCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define CRCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/crcp_pkg.sv
// Types, widths, codes and helper functions of the Catmull-Rom curve point block.
`default_nettype none

package crcp_pkg;

  // Field and register widths
  localparam int COORD_W        = 32;
  localparam int T_W            = 16;
  localparam int FS_W           = T_W + 1;
  localparam int CNT_W          = 7;
  localparam int IDXF_W         = 6;
  localparam int NUM_AXES       = 3;
  localparam int NUM_TAPS       = 4;
  localparam int APB_W          = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_SEL_W      = CFG_ADDR_W - 2;

  // Point count limits and default store depth
  localparam int MAX_POINTS_DEF = 64;
  localparam int NUM_POINTS_MIN = 4;
  localparam int NUM_POINTS_RST = 4;
  localparam int NUM_POINTS_TOP = (1 << CNT_W) - 1;

  // Register index on the configuration port
  localparam logic [CFG_SEL_W-1:0] REG_NUM_POINTS = '0;

  // Stream word layout
  localparam int S_DATA_W  = 120;
  localparam int S_USER_W  = 1;
  localparam int M_DATA_W  = 2 * NUM_AXES * COORD_W;
  localparam int IN_IDX_LSB = 0;
  localparam int IN_X_LSB   = IN_IDX_LSB + IDXF_W;
  localparam int IN_T_LSB   = IN_X_LSB + NUM_AXES * COORD_W;
  localparam int OUT_POS_LSB = 0;
  localparam int OUT_TAN_LSB = NUM_AXES * COORD_W;

  // Coefficient and accumulator widths
  localparam int C3_W  = 35;
  localparam int C2_W  = 36;
  localparam int C1_W  = 33;
  localparam int C0_W  = 33;
  localparam int T3_W  = 37;
  localparam int T2_W  = 37;
  localparam int POS_W = 37;
  localparam int TAN_W = 38;
  localparam int PP_W  = POS_W + FS_W;
  localparam int TP_W  = TAN_W + FS_W;
  localparam int RND_HALF = 1 << (T_W - 1);

  // Pipeline stages
  localparam int ST_IN   = 0;
  localparam int ST_RD   = 1;
  localparam int ST_COEF = 2;
  localparam int ST_P1   = 3;
  localparam int ST_A1   = 4;
  localparam int ST_P2   = 5;
  localparam int ST_A2   = 6;
  localparam int ST_P3   = 7;
  localparam int ST_A3   = 8;
  localparam int ST_OUT  = 9;
  localparam int NSTG    = 10;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] point_t;

  localparam logic signed [TAN_W-1:0] SAT_HI = TAN_W'(2147483647);
  localparam logic signed [TAN_W-1:0] SAT_LO = -SAT_HI - TAN_W'(1);

  // Round a position product back to Q16.16, half up
  function automatic logic signed [POS_W-1:0] rnd_pos(input logic signed [PP_W-1:0] p);
    logic signed [PP_W-1:0] s;
    s = (p + PP_W'(RND_HALF)) >>> T_W;
    return s[POS_W-1:0];
  endfunction

  // Round a tangent product back to Q16.16, half up
  function automatic logic signed [TAN_W-1:0] rnd_tan(input logic signed [TP_W-1:0] p);
    logic signed [TP_W-1:0] s;
    s = (p + TP_W'(RND_HALF)) >>> T_W;
    return s[TAN_W-1:0];
  endfunction

  // Halve with rounding up, then clamp to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat_half(input logic signed [TAN_W-1:0] v);
    logic signed [TAN_W-1:0] h;
    h = (v + TAN_W'(1)) >>> 1;
    if (h > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (h < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end else begin
      return h[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/catmull_rom_curve_point.sv
// Closed-loop Catmull-Rom curve point evaluator: top level.
//
// Stream in write words (tuser 0) that load one control point, or evaluate words
// (tuser 1) that give a Q0.16 curve parameter; each evaluate word returns one
// word with the Q16.16 position and tangent, saturated, write words return
// nothing. The block takes one word per cycle and holds that rate as long as the
// output side takes results. The rate comes from four copies of the point store,
// one per curve tap, each with its own read port, and from the Horner multiplier
// chain cut into registered multiply and round-add stages. Valid bits travel
// with the data and each stage stalls only when the one after it is full.
// Unwritten points read as whatever the store holds; there is no clearing pass
// after reset. num_points (byte address 0) is clamped in use to 4..MAX_POINTS
// but at most 127; write it only while the block is idle.
`default_nettype none

module catmull_rom_curve_point
  import crcp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
  // global_t[117:102], zero[119:118]
  input  logic [S_DATA_W-1:0]   s_tdata,
  // op[0]
  input  logic [S_USER_W-1:0]   s_tuser,
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64],
  // tangent_x[127:96], tangent_y[159:128], tangent_z[191:160]
  output logic [M_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int N_HI  = (MAX_POINTS > NUM_POINTS_TOP) ? NUM_POINTS_TOP : MAX_POINTS;
  localparam logic [CNT_W-1:0] N_LO  = CNT_W'(NUM_POINTS_MIN);
  localparam logic [CNT_W-1:0] N_TOP = CNT_W'(N_HI);

  // Configuration register
  logic             cfg_wr;
  logic [CNT_W-1:0] num_points;
  logic [CNT_W-1:0] n_use;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= CNT_W'(NUM_POINTS_RST);
    end else if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_NUM_POINTS) begin
      num_points <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1:2] == REG_NUM_POINTS) begin
      prdata = APB_W'(num_points);
    end else begin
      prdata = '0;
    end
  end

  // Clamp the point count in use
  always_comb begin
    if (num_points < N_LO) begin
      n_use = N_LO;
    end else if (num_points > N_TOP) begin
      n_use = N_TOP;
    end else begin
      n_use = num_points;
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[ST_IN];
  assign m_tvalid = v[ST_OUT];

  // Valid bits; write words leave the pipe once stored
  logic s0_eval;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[ST_IN]) begin
        v[ST_IN] <= s_tvalid;
      end
      if (en[ST_RD]) begin
        v[ST_RD] <= v[ST_IN] && s0_eval;
      end
      for (int k = ST_COEF; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Input word: unpack and scale the parameter by the point count
  logic [T_W+CNT_W-1:0] in_scaled;
  point_t               in_pt;

  assign in_scaled = (T_W + CNT_W)'(s_tdata[IN_T_LSB +: T_W]) * (T_W + CNT_W)'(n_use);

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      in_pt[ax] = s_tdata[IN_X_LSB + ax * COORD_W +: COORD_W];
    end
  end

  // Stage 0: input register
  op_t              s0_op;
  logic [IDXF_W-1:0] s0_index;
  point_t           s0_pt;
  logic [CNT_W-1:0] s0_seg;
  logic [T_W-1:0]   s0_frac;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      s0_op    <= op_t'(s_tuser[0]);
      s0_index <= s_tdata[IN_IDX_LSB +: IDXF_W];
      s0_pt    <= in_pt;
      s0_seg   <= in_scaled[T_W +: CNT_W];
      s0_frac  <= in_scaled[T_W-1:0];
    end
  end

  assign s0_eval = (s0_op == OP_EVAL);

  // Tap indices with wrap-around, one point before the segment up to two after
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] tap [NUM_TAPS];
  logic [IDX_W-1:0] rd_addr [NUM_TAPS];
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    n_m1   = n_use - CNT_W'(1);
    tap[0] = (s0_seg == '0) ? n_m1 : s0_seg - CNT_W'(1);
    tap[1] = s0_seg;
    tap[2] = (s0_seg == n_m1) ? '0 : s0_seg + CNT_W'(1);
    tap[3] = (tap[2] == n_m1) ? '0 : tap[2] + CNT_W'(1);
    for (int j = 0; j < NUM_TAPS; j++) begin
      rd_addr[j] = IDX_W'(tap[j]);
    end
  end

  assign wr_addr = IDX_W'(s0_index);
  assign wr_en   = v[ST_IN] && en[ST_RD] && (s0_op == OP_WRITE)
                   && (32'(s0_index) < MAX_POINTS);
  assign rd_en   = v[ST_IN] && en[ST_RD] && s0_eval;

  // Stage 1: one store copy per tap, all written alike, each read at its tap
  point_t         s1_pt [NUM_TAPS];
  logic [T_W-1:0] s1_frac;

  for (genvar c = 0; c < NUM_TAPS; c++) begin : g_copy
    point_t store [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        store[wr_addr] <= s0_pt;
      end
      if (rd_en) begin
        s1_pt[c] <= store[rd_addr[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_RD]) begin
      s1_frac <= s0_frac;
    end
  end

  // Stage 2: twice the basis coefficients per axis
  logic signed [TAN_W-1:0] ext [NUM_AXES][NUM_TAPS];
  logic signed [TAN_W-1:0] c3_full [NUM_AXES];
  logic signed [TAN_W-1:0] c2_full [NUM_AXES];

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        ext[ax][j] = TAN_W'($signed(s1_pt[j][ax]));
      end
      c3_full[ax] = -ext[ax][0] + TAN_W'(3) * ext[ax][1]
                    - TAN_W'(3) * ext[ax][2] + ext[ax][3];
      c2_full[ax] = TAN_W'(2) * ext[ax][0] - TAN_W'(5) * ext[ax][1]
                    + TAN_W'(4) * ext[ax][2] - ext[ax][3];
    end
  end

  logic signed [FS_W-1:0] s2_fs;
  logic signed [C3_W-1:0] s2_c3 [NUM_AXES];
  logic signed [C2_W-1:0] s2_c2 [NUM_AXES];
  logic signed [C1_W-1:0] s2_c1 [NUM_AXES];
  logic signed [C0_W-1:0] s2_c0 [NUM_AXES];
  logic signed [T3_W-1:0] s2_t3 [NUM_AXES];
  logic signed [T2_W-1:0] s2_t2 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_COEF]) begin
      s2_fs <= $signed({1'b0, s1_frac});
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s2_c3[ax] <= C3_W'(c3_full[ax]);
        s2_c2[ax] <= C2_W'(c2_full[ax]);
        s2_c1[ax] <= C1_W'(ext[ax][2] - ext[ax][0]);
        s2_c0[ax] <= C0_W'(TAN_W'(2) * ext[ax][1]);
        s2_t3[ax] <= T3_W'(TAN_W'(3) * c3_full[ax]);
        s2_t2[ax] <= T2_W'(TAN_W'(2) * c2_full[ax]);
      end
    end
  end

  // Stage 3: first Horner product
  logic signed [FS_W-1:0] s3_fs;
  logic signed [PP_W-1:0] s3_pm [NUM_AXES];
  logic signed [TP_W-1:0] s3_tm [NUM_AXES];
  logic signed [C2_W-1:0] s3_c2 [NUM_AXES];
  logic signed [T2_W-1:0] s3_t2 [NUM_AXES];
  logic signed [C1_W-1:0] s3_c1 [NUM_AXES];
  logic signed [C0_W-1:0] s3_c0 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      s3_fs <= s2_fs;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s3_pm[ax] <= PP_W'(s2_c3[ax]) * PP_W'(s2_fs);
        s3_tm[ax] <= TP_W'(s2_t3[ax]) * TP_W'(s2_fs);
        s3_c2[ax] <= s2_c2[ax];
        s3_t2[ax] <= s2_t2[ax];
        s3_c1[ax] <= s2_c1[ax];
        s3_c0[ax] <= s2_c0[ax];
      end
    end
  end

  // Stage 4: round and add the next coefficient
  logic signed [FS_W-1:0]  s4_fs;
  logic signed [POS_W-1:0] s4_pa [NUM_AXES];
  logic signed [TAN_W-1:0] s4_ta [NUM_AXES];
  logic signed [C1_W-1:0]  s4_c1 [NUM_AXES];
  logic signed [C0_W-1:0]  s4_c0 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_A1]) begin
      s4_fs <= s3_fs;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s4_pa[ax] <= rnd_pos(s3_pm[ax]) + POS_W'(s3_c2[ax]);
        s4_ta[ax] <= rnd_tan(s3_tm[ax]) + TAN_W'(s3_t2[ax]);
        s4_c1[ax] <= s3_c1[ax];
        s4_c0[ax] <= s3_c0[ax];
      end
    end
  end

  // Stage 5: second Horner product
  logic signed [FS_W-1:0] s5_fs;
  logic signed [PP_W-1:0] s5_pm [NUM_AXES];
  logic signed [TP_W-1:0] s5_tm [NUM_AXES];
  logic signed [C1_W-1:0] s5_c1 [NUM_AXES];
  logic signed [C0_W-1:0] s5_c0 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      s5_fs <= s4_fs;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s5_pm[ax] <= PP_W'(s4_pa[ax]) * PP_W'(s4_fs);
        s5_tm[ax] <= TP_W'(s4_ta[ax]) * TP_W'(s4_fs);
        s5_c1[ax] <= s4_c1[ax];
        s5_c0[ax] <= s4_c0[ax];
      end
    end
  end

  // Stage 6: round and add; the tangent is complete here
  logic signed [FS_W-1:0]  s6_fs;
  logic signed [POS_W-1:0] s6_pa [NUM_AXES];
  logic signed [TAN_W-1:0] s6_ta [NUM_AXES];
  logic signed [C0_W-1:0]  s6_c0 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_A2]) begin
      s6_fs <= s5_fs;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s6_pa[ax] <= rnd_pos(s5_pm[ax]) + POS_W'(s5_c1[ax]);
        s6_ta[ax] <= rnd_tan(s5_tm[ax]) + TAN_W'(s5_c1[ax]);
        s6_c0[ax] <= s5_c0[ax];
      end
    end
  end

  // Stage 7: third position product
  logic signed [PP_W-1:0]  s7_pm [NUM_AXES];
  logic signed [TAN_W-1:0] s7_ta [NUM_AXES];
  logic signed [C0_W-1:0]  s7_c0 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_P3]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s7_pm[ax] <= PP_W'(s6_pa[ax]) * PP_W'(s6_fs);
        s7_ta[ax] <= s6_ta[ax];
        s7_c0[ax] <= s6_c0[ax];
      end
    end
  end

  // Stage 8: final round and add for the position
  logic signed [POS_W-1:0] s8_pa [NUM_AXES];
  logic signed [TAN_W-1:0] s8_ta [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_A3]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s8_pa[ax] <= rnd_pos(s7_pm[ax]) + POS_W'(s7_c0[ax]);
        s8_ta[ax] <= s7_ta[ax];
      end
    end
  end

  // Stage 9: halve, saturate and hold for the output side
  logic [COORD_W-1:0] s9_pos [NUM_AXES];
  logic [COORD_W-1:0] s9_tan [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s9_pos[ax] <= sat_half(TAN_W'(s8_pa[ax]));
        s9_tan[ax] <= sat_half(s8_ta[ax]);
      end
    end
  end

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      m_tdata[OUT_POS_LSB + ax * COORD_W +: COORD_W] = s9_pos[ax];
      m_tdata[OUT_TAN_LSB + ax * COORD_W +: COORD_W] = s9_tan[ax];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crcp_checker.sv
// Port-level checker for the curve point block, bound to its top level.
`default_nettype none

`include "catmull_rom_curve_point_assert.svh"

module crcp_checker
  import crcp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [APB_W-1:0]      pwdata,
  input wire logic [APB_W-1:0]      prdata,
  input wire logic                  pready,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [M_DATA_W-1:0]   m_tdata
);

  // Hold a stalled result word
  `CRCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped or changed while stalled")

  // Come out of reset with no result pending
  `CRCP_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "result word present right after reset")

  // An empty output stage means the whole pipe can advance
  `CRCP_ASSERT_NOW(a_ready_when_drained, !m_tvalid, s_tready, "input stalled while no result is waiting")

  // A written point count reads back on the next cycle
  `CRCP_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_NUM_POINTS, paddr[CFG_ADDR_W-1:2] != REG_NUM_POINTS || prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]), "point count readback mismatch")

endmodule

bind catmull_rom_curve_point crcp_checker u_crcp_checker (.*);

`default_nettype wire

### tb/catmull_rom_curve_point_tb.sv
// Self-checking testbench for the closed-loop Catmull-Rom curve point evaluator.
module catmull_rom_curve_point_tb;
  import crcp_pkg::*;

  localparam coord_t C_MAX = 32'h7FFF_FFFF;
  localparam coord_t C_MIN = 32'h8000_0000;
  localparam int PHASES = 11;
  localparam int PHASE_WORDS = 135;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    coord_t pos_x, pos_y, pos_z;
    coord_t tangent_x, tangent_y, tangent_z;
  } curve_pt_t;

  typedef struct packed {
    op_t           op;
    logic [5:0]    slot;
    coord_t        x, y, z;
    logic [15:0]   gt;
    logic          typed;
    curve_pt_t     want;
  } stim_row_t;

  typedef struct packed {
    logic      typed;
    curve_pt_t want;
  } word_note_t;

  // Block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]      pwdata = '0;
  logic [APB_W-1:0]      prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
  // global_t[117:102], zero[119:118]
  logic [S_DATA_W-1:0]   s_tdata = '0;
  // op[0]
  logic [S_USER_W-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // pos_x[31:0], pos_y[63:32], pos_z[95:64],
  // tangent_x[127:96], tangent_y[159:128], tangent_z[191:160]
  logic [M_DATA_W-1:0]   m_tdata;

  // Mirror of the block state
  coord_t     pt_store [NUM_AXES][MAX_POINTS_DEF];
  logic [6:0] cfg_points = 7'(NUM_POINTS_RST);

  curve_pt_t  expected_pts [$];
  word_note_t word_notes [$];
  int unsigned fail_count = 0;

  // Traffic shaping
  bit          tx_bursty = 1'b1;
  int unsigned burst_left = 0;
  bit          rx_stall = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit          rdy_state = 1'b1;

  // Input monitor scratch
  word_note_t in_note;
  // Output monitor scratch
  curve_pt_t  out_want, out_got;

  // Directed words: extremes, saturation, small values, segment ends
  stim_row_t dir_rows [23] = '{
    '{OP_WRITE, 6'd0, C_MAX, C_MIN, 32'sd0, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd1, C_MAX, C_MIN, 32'sd0, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd2, C_MAX, C_MIN, 32'sd0, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd3, C_MAX, C_MIN, 32'sd0, 16'h0000, 1'b0, '0},
    // equal points: position is the point, tangent is zero
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000, 1'b1,
      '{C_MAX, C_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 1'b1,
      '{C_MAX, C_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h8000, 1'b1,
      '{C_MAX, C_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    // alternating extremes drive the sums past 32 bits
    '{OP_WRITE, 6'd1, C_MIN, C_MAX, 32'sd1, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd3, C_MIN, C_MAX, 32'sd1, 16'h0000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h4000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'hC000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h2000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h0001, 1'b0, '0},
    // small coordinates with a mix of signs
    '{OP_WRITE, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd1, 32'sh10000, -32'sh10000, 32'sh8000, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd2, 32'sh20000, 32'sh30000, -32'sd1, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 6'd3, 32'sh30000, 32'sh5000, 32'sh7FFF0000, 16'h0000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h4000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h8000, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 1'b0, '0},
    '{OP_EVAL, 6'd0, 32'sd0, 32'sd0, 32'sd0, 16'h0100, 1'b0, '0}
  };

  logic [6:0] point_counts [PHASES] = '{
    7'd4, 7'd64, 7'd127, 7'd0, 7'd3, 7'd5, 7'd17, 7'd65, 7'd33, 7'd63, 7'd0
  };

  catmull_rom_curve_point DUT (.*);

  always #1 clk = ~clk;

  // Run limit
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void count_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input coord_t want, input coord_t got);
    if (want !== got) count_fail($sformatf("%s: expected %h, got %h", name, want, got));
  endfunction

  // Clamp the count register to the usable loop size
  function automatic int unsigned points_in_use();
    if (cfg_points < NUM_POINTS_MIN) return NUM_POINTS_MIN;
    if (cfg_points > MAX_POINTS_DEF) return MAX_POINTS_DEF;
    return cfg_points;
  endfunction

  // Round a Q32.32 product to Q16.16, half up
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic coord_t clamp_q16(input longint v);
    if (v > 64'sd2147483647) return C_MAX;
    if (v < -64'sd2147483648) return C_MIN;
    return v[31:0];
  endfunction

  // Horner evaluation on doubled coefficients, then halve and saturate
  function automatic void spline_axis(input longint p0, p1, p2, p3, input longint f,
                                      output coord_t pos, output coord_t slope);
    longint c3, c2, c1, c0, acc;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    c0 = 2 * p1;
    acc = round_q16(c3 * f) + c2;
    acc = round_q16(acc * f) + c1;
    acc = round_q16(acc * f) + c0;
    pos = clamp_q16((acc + 1) >>> 1);
    acc = round_q16(3 * c3 * f) + 2 * c2;
    acc = round_q16(acc * f) + c1;
    slope = clamp_q16((acc + 1) >>> 1);
  endfunction

  // Curve position and tangent for one global parameter
  function automatic curve_pt_t eval_curve(input logic [15:0] gt);
    int unsigned n, scaled, seg;
    int unsigned tap [NUM_TAPS];
    longint f;
    coord_t pos [NUM_AXES];
    coord_t slope [NUM_AXES];
    curve_pt_t r;
    n = points_in_use();
    scaled = gt * n;
    seg = scaled >> 16;
    f = longint'(scaled & 32'hFFFF);
    tap[0] = (seg + n - 1) % n;
    for (int k = 1; k < NUM_TAPS; k++) tap[k] = (tap[k-1] + 1) % n;
    for (int a = 0; a < NUM_AXES; a++) begin
      spline_axis(pt_store[a][tap[0]], pt_store[a][tap[1]], pt_store[a][tap[2]],
                  pt_store[a][tap[3]], f, pos[a], slope[a]);
    end
    r = '{pos[0], pos[1], pos[2], slope[0], slope[1], slope[2]};
    return r;
  endfunction

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4, 5: return {{10{r[21]}}, r[21:0]};
      default: return r;
    endcase
  endfunction

  // Bias the parameter toward segment boundaries and the ends of the range
  function automatic logic [15:0] rand_param();
    int unsigned n, k;
    n = points_in_use();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: begin
        k = $urandom_range(0, n - 1);
        return 16'((k * 65536 + n - 1) / n + $urandom_range(0, 2) - 1);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until taken; start and end at a falling edge
  task automatic send_word(input op_t op, input logic [5:0] slot, input coord_t x, y, z,
                           input logic [15:0] gt, input logic typed, input curve_pt_t want);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    word_notes.insert(word_notes.size(), word_note_t'{typed, want});
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, gt, z, y, x, slot};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let writes settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_pts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the point count, then read it back
  task automatic set_point_count(input logic [6:0] count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({REG_NUM_POINTS, 2'b00});
    pwdata  <= {{(APB_W-CNT_W){1'b0}}, count};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_points = count;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(APB_W-CNT_W){1'b0}}, count})
      count_fail($sformatf("num_points readback: expected %h, got %h", count, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Track accepted words: update the point store or queue the expected result
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      in_note = word_notes.pop_front();
      if (s_tuser[0] == OP_WRITE) begin
        pt_store[0][s_tdata[5:0]] = s_tdata[37:6];
        pt_store[1][s_tdata[5:0]] = s_tdata[69:38];
        pt_store[2][s_tdata[5:0]] = s_tdata[101:70];
      end else begin
        expected_pts.insert(expected_pts.size(),
                            in_note.typed ? in_note.want : eval_curve(s_tdata[117:102]));
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pts.size() == 0) begin
        count_fail($sformatf("result word with nothing expected: %h", m_tdata));
      end else begin
        out_want = expected_pts.pop_front();
        out_got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                    m_tdata[127:96], m_tdata[159:128], m_tdata[191:160]};
        check_field("pos_x", out_want.pos_x, out_got.pos_x);
        check_field("pos_y", out_want.pos_y, out_got.pos_y);
        check_field("pos_z", out_want.pos_z, out_got.pos_z);
        check_field("tangent_x", out_want.tangent_x, out_got.tangent_x);
        check_field("tangent_y", out_want.tangent_y, out_got.tangent_y);
        check_field("tangent_z", out_want.tangent_z, out_got.tangent_z);
      end
    end
  end

  // Receiver: long hold-off on request, else ready/stall runs or always ready
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (!rx_stall) begin
        m_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy_state = ~rdy_state;
          run_left = rdy_state ? $urandom_range(1, 10) : $urandom_range(1, 5);
        end
        run_left--;
        m_tready <= rdy_state;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset point count
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].z, dir_rows[i].gt, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_drained();

    // Fill every slot so later evaluations only read written points
    for (int s = 0; s < MAX_POINTS_DEF; s++) begin
      send_word(OP_WRITE, 6'(s), rand_coord(), rand_coord(), rand_coord(), 16'h0,
                1'b0, '0);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_point_count(p == PHASES - 1 ? 7'($urandom_range(0, 127)) : point_counts[p]);
      tx_bursty = (p != 1 && p != 5);
      rx_stall = (p != 5);
      // Back up the output while input keeps coming
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 99) < 30) begin
          send_word(OP_WRITE, 6'($urandom_range(0, MAX_POINTS_DEF - 1)), rand_coord(),
                    rand_coord(), rand_coord(), 16'($urandom), 1'b0, '0);
        end else begin
          send_word(OP_EVAL, 6'($urandom), rand_coord(), rand_coord(), rand_coord(),
                    rand_param(), 1'b0, '0);
        end
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_pts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/crcp_pkg.sv
hw/rtl/catmull_rom_curve_point.sv
hw/rtl/crcp_checker.sv
tb/catmull_rom_curve_point_tb.sv
